### src/ensc_pkg.sv
package ensc_pkg;

   localparam int unsigned DIV_LAT   = 32;
   localparam int unsigned PRE_LAT   = 7;
   localparam int unsigned POST_LAT  = 4;
   localparam int unsigned HUM_LAT   = 11;
   localparam int unsigned ALIGN_LAT = PRE_LAT + DIV_LAT + POST_LAT - HUM_LAT;

   localparam logic [2:0] REG_TEMP   = 3'd0;
   localparam logic [2:0] REG_PRESSA = 3'd1;
   localparam logic [2:0] REG_PRESSB = 3'd2;
   localparam logic [2:0] REG_PRESSC = 3'd3;
   localparam logic [2:0] REG_HUM    = 3'd4;

   localparam logic signed [31:0] TEMP_MIN    = -32'sd4000;
   localparam logic signed [31:0] TEMP_MAX    = 32'sd8500;
   localparam logic [31:0]        PRESS_MIN   = 32'd30000;
   localparam logic [31:0]        PRESS_MAX   = 32'd110000;
   localparam logic signed [31:0] HUM_RAW_MAX = 32'sd419430400;
   localparam logic [31:0]        HUM_MAX     = 32'd102400;

   typedef struct packed {
      logic [19:0] raw_pressure;
      logic [19:0] raw_temperature;
      logic [15:0] raw_humidity;
   } req_type;

   typedef struct packed {
      logic signed [14:0] temperature_centi;
      logic [16:0]        pressure_pa;
      logic [16:0]        humidity_q10;
   } rsp_type;

   typedef struct packed {
      logic [31:0] t1, t2, t3;
      logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
   } cal_type;

   typedef struct packed {
      logic [31:0] pa;
      logic [31:0] ha;
      logic [19:0] rp;
      logic [15:0] rh;
      logic [14:0] temp;
   } front_type;

   typedef struct packed {
      logic [31:0] num;
      logic [31:0] den;
      logic        dbl;
      logic        zero;
   } div_in_type;

   typedef struct packed {
      logic [31:0] num;
      logic [31:0] den;
      logic [31:0] rem;
      logic [31:0] quot;
      logic        dbl;
      logic        zero;
   } div_stage_type;

   typedef struct packed {
      logic [31:0] quot;
      logic        dbl;
      logic        zero;
   } div_out_type;

   // signed shift right, rounding toward zero
   function automatic logic [31:0] sdiv(input logic [31:0] x, input logic [4:0] k);
      logic [31:0] n;
      n = 32'd0 - x;
      return x[31] ? (32'd0 - (n >> k)) : (x >> k);
   endfunction

endpackage

### src/ensc_temp.sv
module ensc_temp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  ensc_pkg::req_type    in_word,
   input  ensc_pkg::cal_type    cal,
   output logic                 out_valid,
   output ensc_pkg::front_type  out_word
);
   logic [5:0]  vld_ff;
   logic [31:0] rp1_ff, rt1_ff, rh1_ff;
   logic [31:0] ta_ff, tb_ff, a1_ff, bb_ff, a2_ff, b2_ff, fine_ff;
   logic [19:0] rp_ff [3:0];
   logic [15:0] rh_ff [3:0];
   ensc_pkg::front_type out_ff, out_in;
   logic [31:0] fine_in, tsr;
   logic signed [31:0] ts;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_comb begin
      fine_in = a2_ff + ensc_pkg::sdiv(b2_ff, 5'd14);
      tsr = ensc_pkg::sdiv(32'(fine_ff * 32'd5) + 32'd128, 5'd8);
      ts = signed'(tsr);
      out_in.pa = ensc_pkg::sdiv(fine_ff, 5'd1) - 32'd64000;
      out_in.ha = fine_ff - 32'd76800;
      out_in.rp = rp_ff[3];
      out_in.rh = rh_ff[3];
      priority if (ts < ensc_pkg::TEMP_MIN) begin
         out_in.temp = ensc_pkg::TEMP_MIN[14:0];
      end else if (ts > ensc_pkg::TEMP_MAX) begin
         out_in.temp = ensc_pkg::TEMP_MAX[14:0];
      end else begin
         out_in.temp = tsr[14:0];
      end
   end

   always_ff @(posedge clock) begin
      rp1_ff  <= {12'd0, in_word.raw_pressure};
      rt1_ff  <= {12'd0, in_word.raw_temperature};
      rh1_ff  <= {16'd0, in_word.raw_humidity};
      ta_ff   <= (rt1_ff >> 3) - 32'(cal.t1 * 32'd2);
      tb_ff   <= (rt1_ff >> 4) - cal.t1;
      a1_ff   <= 32'(ta_ff * cal.t2);
      bb_ff   <= 32'(tb_ff * tb_ff);
      a2_ff   <= ensc_pkg::sdiv(a1_ff, 5'd11);
      b2_ff   <= 32'(ensc_pkg::sdiv(bb_ff, 5'd12) * cal.t3);
      fine_ff <= fine_in;
      out_ff  <= out_in;
      rp_ff[0] <= rp1_ff[19:0];
      rh_ff[0] <= rh1_ff[15:0];
      for (int i = 1; i < 4; i++) begin
         rp_ff[i] <= rp_ff[i-1];
         rh_ff[i] <= rh_ff[i-1];
      end
   end

   assign out_valid = vld_ff[5];
   assign out_word  = out_ff;
endmodule

### src/ensc_press_pre.sv
module ensc_press_pre (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  ensc_pkg::front_type   in_word,
   input  ensc_pkg::cal_type     cal,
   output logic                  out_valid,
   output ensc_pkg::div_in_type  out_word
);
   logic [ensc_pkg::PRE_LAT-1:0] vld_ff;
   logic [31:0] qq_ff, ap5_ff, dd_ff, rp7_ff;
   logic [31:0] b_ff, c0_ff, ap5b_ff, ddb_ff, rp8_ff;
   logic [31:0] bsum_ff, x_ff, rp9_ff;
   logic [31:0] m_ff, bsum10_ff, rp10_ff;
   logic [31:0] a_ff, p0_ff;
   logic [31:0] pm_ff, a12_ff;
   logic [31:0] q, bsum_in, x_in;
   ensc_pkg::div_in_type out_ff, out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[ensc_pkg::PRE_LAT-2:0], in_valid};
      end
   end

   always_comb begin
      q = ensc_pkg::sdiv(in_word.pa, 5'd2);
      bsum_in = ensc_pkg::sdiv(b_ff + 32'(ap5b_ff * 32'd2), 5'd2)
              + 32'(cal.p4 * 32'd65536);
      x_in = 32'd32768 + ensc_pkg::sdiv(ensc_pkg::sdiv(c0_ff, 5'd3)
              + ensc_pkg::sdiv(ddb_ff, 5'd1), 5'd18);
      out_in.num  = pm_ff[31] ? pm_ff : (pm_ff << 1);
      out_in.den  = a12_ff;
      out_in.dbl  = pm_ff[31];
      out_in.zero = (a12_ff == 32'd0);
   end

   always_ff @(posedge clock) begin
      qq_ff     <= 32'(q * q);
      ap5_ff    <= 32'(in_word.pa * cal.p5);
      dd_ff     <= 32'(cal.p2 * in_word.pa);
      rp7_ff    <= {12'd0, in_word.rp};
      b_ff      <= 32'(ensc_pkg::sdiv(qq_ff, 5'd11) * cal.p6);
      c0_ff     <= 32'(cal.p3 * ensc_pkg::sdiv(qq_ff, 5'd13));
      ap5b_ff   <= ap5_ff;
      ddb_ff    <= dd_ff;
      rp8_ff    <= rp7_ff;
      bsum_ff   <= bsum_in;
      x_ff      <= x_in;
      rp9_ff    <= rp8_ff;
      m_ff      <= 32'(x_ff * cal.p1);
      bsum10_ff <= bsum_ff;
      rp10_ff   <= rp9_ff;
      a_ff      <= ensc_pkg::sdiv(m_ff, 5'd15);
      p0_ff     <= (32'd1048576 - rp10_ff) - ensc_pkg::sdiv(bsum10_ff, 5'd12);
      pm_ff     <= 32'(p0_ff * 32'd3125);
      a12_ff    <= a_ff;
      out_ff    <= out_in;
   end

   assign out_valid = vld_ff[ensc_pkg::PRE_LAT-1];
   assign out_word  = out_ff;
endmodule

### src/ensc_div.sv
module ensc_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  ensc_pkg::div_in_type   in_word,
   output logic                   out_valid,
   output ensc_pkg::div_out_type  out_word
);
   localparam int unsigned N = ensc_pkg::DIV_LAT;

   logic [N-1:0] vld_ff;
   ensc_pkg::div_stage_type st_ff [N-1:0];
   ensc_pkg::div_stage_type st_in [N-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[N-2:0], in_valid};
      end
   end

   // one quotient bit per stage, restoring
   always_comb begin
      ensc_pkg::div_stage_type src;
      logic [32:0] rem2;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            src.num  = in_word.num;
            src.den  = in_word.den;
            src.rem  = 32'd0;
            src.quot = 32'd0;
            src.dbl  = in_word.dbl;
            src.zero = in_word.zero;
         end else begin
            src = st_ff[i-1];
         end
         rem2 = {src.rem, src.num[31]};
         st_in[i] = src;
         st_in[i].num = src.num << 1;
         if (rem2 >= {1'b0, src.den}) begin
            st_in[i].rem  = 32'(rem2 - {1'b0, src.den});
            st_in[i].quot = {src.quot[30:0], 1'b1};
         end else begin
            st_in[i].rem  = rem2[31:0];
            st_in[i].quot = {src.quot[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         st_ff[i] <= st_in[i];
      end
   end

   assign out_valid     = vld_ff[N-1];
   assign out_word.quot = st_ff[N-1].quot;
   assign out_word.dbl  = st_ff[N-1].dbl;
   assign out_word.zero = st_ff[N-1].zero;
endmodule

### src/ensc_press_post.sv
module ensc_press_post (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  ensc_pkg::div_out_type  in_word,
   input  ensc_pkg::cal_type      cal,
   output logic                   out_valid,
   output logic [16:0]            out_press
);
   logic [ensc_pkg::POST_LAT-1:0] vld_ff;
   logic [31:0] p_ff, sq_ff, pp8_ff, p47_ff, c0_ff, pp8b_ff, p48_ff;
   logic        z_ff, z47_ff, z48_ff;
   logic [16:0] press_ff, press_in;
   logic [31:0] pf;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[ensc_pkg::POST_LAT-2:0], in_valid};
      end
   end

   always_comb begin
      pf = p48_ff + ensc_pkg::sdiv(ensc_pkg::sdiv(c0_ff, 5'd12)
         + ensc_pkg::sdiv(pp8b_ff, 5'd13) + cal.p7, 5'd4);
      priority if (z48_ff) begin
         press_in = ensc_pkg::PRESS_MIN[16:0];
      end else if (pf < ensc_pkg::PRESS_MIN) begin
         press_in = ensc_pkg::PRESS_MIN[16:0];
      end else if (pf > ensc_pkg::PRESS_MAX) begin
         press_in = ensc_pkg::PRESS_MAX[16:0];
      end else begin
         press_in = pf[16:0];
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= in_word.dbl ? (in_word.quot << 1) : in_word.quot;
      z_ff     <= in_word.zero;
      sq_ff    <= 32'((p_ff >> 3) * (p_ff >> 3));
      pp8_ff   <= 32'((p_ff >> 2) * cal.p8);
      p47_ff   <= p_ff;
      z47_ff   <= z_ff;
      c0_ff    <= 32'(cal.p9 * (sq_ff >> 13));
      pp8b_ff  <= pp8_ff;
      p48_ff   <= p47_ff;
      z48_ff   <= z47_ff;
      press_ff <= press_in;
   end

   assign out_valid = vld_ff[ensc_pkg::POST_LAT-1];
   assign out_press = press_ff;
endmodule

### src/ensc_hum.sv
module ensc_hum (
   input  logic                 clock,
   input  ensc_pkg::front_type  in_word,
   input  ensc_pkg::cal_type    cal,
   output logic [14:0]          out_temp,
   output logic [16:0]          out_hum
);
   logic [31:0] d1_ff, hb_ff, hc_ff, bmc_ff;
   logic [31:0] e_ff [4:0];
   logic [31:0] b_ff, cc_ff, m_ff, d_ff, m2_ff, bq_ff, c_ff, s_ff, c14_ff, d0_ff, c15_ff;
   logic [31:0] dh_ff, c16_ff;
   logic [14:0] temp_ff [10:0];
   logic [16:0] hum_ff, hum_in;
   logic [31:0] ef;
   logic signed [31:0] hs;

   always_comb begin
      ef = c16_ff - ensc_pkg::sdiv(dh_ff, 5'd4);
      hs = signed'(ef);
      priority if (hs < 32'sd0) begin
         hum_in = 17'd0;
      end else if (hs > ensc_pkg::HUM_RAW_MAX) begin
         hum_in = ensc_pkg::HUM_MAX[16:0];
      end else begin
         hum_in = ef[28:12];
      end
   end

   always_ff @(posedge clock) begin
      d1_ff  <= 32'(cal.h5 * in_word.ha);
      hb_ff  <= 32'(in_word.ha * cal.h6);
      hc_ff  <= 32'(in_word.ha * cal.h3);
      bmc_ff <= {2'd0, in_word.rh, 14'd0} - (cal.h4 << 20);
      e_ff[0] <= ensc_pkg::sdiv(bmc_ff - d1_ff + 32'd16384, 5'd15);
      b_ff   <= ensc_pkg::sdiv(hb_ff, 5'd10);
      cc_ff  <= ensc_pkg::sdiv(hc_ff, 5'd11) + 32'd32768;
      m_ff   <= 32'(b_ff * cc_ff);
      d_ff   <= ensc_pkg::sdiv(m_ff, 5'd10) + 32'd2097152;
      m2_ff  <= 32'(d_ff * cal.h2) + 32'd8192;
      bq_ff  <= ensc_pkg::sdiv(m2_ff, 5'd14);
      c_ff   <= 32'(e_ff[4] * bq_ff);
      s_ff   <= ensc_pkg::sdiv(c_ff, 5'd15);
      c14_ff <= c_ff;
      d0_ff  <= 32'(s_ff * s_ff);
      c15_ff <= c14_ff;
      dh_ff  <= 32'(ensc_pkg::sdiv(d0_ff, 5'd7) * cal.h1);
      c16_ff <= c15_ff;
      hum_ff <= hum_in;
      for (int i = 1; i < 5; i++) begin
         e_ff[i] <= e_ff[i-1];
      end
      temp_ff[0] <= in_word.temp;
      for (int i = 1; i < 11; i++) begin
         temp_ff[i] <= temp_ff[i-1];
      end
   end

   assign out_temp = temp_ff[10];
   assign out_hum  = hum_ff;
endmodule

### src/env_sensor_compensation.sv
// environmental sensor compensation engine
// req channel: raise start with a raw triple on req_word; it is taken at any
// edge where start is high and busy is low. busy never rises, so one word
// may enter every clock cycle.
// rsp channel: rsp_valid strobes for one cycle with the compensated word on
// rsp_word. one rsp word per req word, in order. the receiver cannot stall,
// so none is needed: results stream out at the accepted rate.
// latency is set by the 32-stage pipelined divider of the pressure path plus
// the temperature, coefficient and correction stages around it.
// csr channel: csr_valid/csr_ready with csr_index and csr_wdata load the five
// calibration words; unknown indexes are dropped. write only while the
// pipeline is empty.
// reset (synchronous) clears calibration and all pipeline valid bits; the
// block is ready in the next cycle.
module env_sensor_compensation (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ensc_pkg::req_type  req_word,
   output logic               rsp_valid,
   output ensc_pkg::rsp_type  rsp_word,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);
   logic [47:0] temp_cal_ff, pa_cal_ff, pb_cal_ff, pc_cal_ff;
   logic [63:0] hum_cal_ff;
   ensc_pkg::cal_type    cal;
   logic                 front_valid, pre_valid, div_valid, post_valid;
   ensc_pkg::front_type  front_word;
   ensc_pkg::div_in_type pre_word;
   ensc_pkg::div_out_type div_word;
   logic [16:0]          press;
   logic [14:0]          temp;
   logic [16:0]          hum;
   logic [31:0]          side_ff [ensc_pkg::ALIGN_LAT-1:0];
   logic                 out_valid_ff;
   ensc_pkg::rsp_type    out_ff, out_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff <= '0;
         pa_cal_ff   <= '0;
         pb_cal_ff   <= '0;
         pc_cal_ff   <= '0;
         hum_cal_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            ensc_pkg::REG_TEMP:   temp_cal_ff <= csr_wdata[47:0];
            ensc_pkg::REG_PRESSA: pa_cal_ff   <= csr_wdata[47:0];
            ensc_pkg::REG_PRESSB: pb_cal_ff   <= csr_wdata[47:0];
            ensc_pkg::REG_PRESSC: pc_cal_ff   <= csr_wdata[47:0];
            ensc_pkg::REG_HUM:    hum_cal_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cal.t1 = {16'd0, temp_cal_ff[15:0]};
      cal.t2 = 32'(signed'(temp_cal_ff[31:16]));
      cal.t3 = 32'(signed'(temp_cal_ff[47:32]));
      cal.p1 = {16'd0, pa_cal_ff[15:0]};
      cal.p2 = 32'(signed'(pa_cal_ff[31:16]));
      cal.p3 = 32'(signed'(pa_cal_ff[47:32]));
      cal.p4 = 32'(signed'(pb_cal_ff[15:0]));
      cal.p5 = 32'(signed'(pb_cal_ff[31:16]));
      cal.p6 = 32'(signed'(pb_cal_ff[47:32]));
      cal.p7 = 32'(signed'(pc_cal_ff[15:0]));
      cal.p8 = 32'(signed'(pc_cal_ff[31:16]));
      cal.p9 = 32'(signed'(pc_cal_ff[47:32]));
      cal.h1 = {24'd0, hum_cal_ff[7:0]};
      cal.h2 = 32'(signed'(hum_cal_ff[23:8]));
      cal.h3 = {24'd0, hum_cal_ff[31:24]};
      cal.h4 = 32'(signed'(hum_cal_ff[43:32]));
      cal.h5 = 32'(signed'(hum_cal_ff[55:44]));
      cal.h6 = 32'(signed'(hum_cal_ff[63:56]));
   end

   ensc_temp u_temp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_word   (req_word),
      .cal       (cal),
      .out_valid (front_valid),
      .out_word  (front_word)
   );

   ensc_press_pre u_pre (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_word   (front_word),
      .cal       (cal),
      .out_valid (pre_valid),
      .out_word  (pre_word)
   );

   ensc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pre_valid),
      .in_word   (pre_word),
      .out_valid (div_valid),
      .out_word  (div_word)
   );

   ensc_press_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_word   (div_word),
      .cal       (cal),
      .out_valid (post_valid),
      .out_press (press)
   );

   ensc_hum u_hum (
      .clock    (clock),
      .in_word  (front_word),
      .cal      (cal),
      .out_temp (temp),
      .out_hum  (hum)
   );

   // line up temperature and humidity with the pressure path
   always_ff @(posedge clock) begin
      side_ff[0] <= {temp, hum};
      for (int i = 1; i < ensc_pkg::ALIGN_LAT; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   always_comb begin
      out_in.temperature_centi = signed'(side_ff[ensc_pkg::ALIGN_LAT-1][31:17]);
      out_in.pressure_pa       = press;
      out_in.humidity_q10      = side_ff[ensc_pkg::ALIGN_LAT-1][16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= post_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;
endmodule

### dv/env_sensor_compensation_tb.sv
`timescale 1ns / 1ps

module env_sensor_compensation_tb;

   localparam int unsigned LATENCY = 50;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   ensc_pkg::req_type   req_word;
   logic                rsp_valid;
   ensc_pkg::rsp_type   rsp_word;
   logic                csr_valid;
   logic                csr_ready;
   logic [2:0]          csr_index;
   logic [63:0]         csr_wdata;

   logic [63:0]         cal_words [0:4];
   ensc_pkg::rsp_type   pending_rsp [$];
   int                  error_count;
   int                  idle_pct;

   typedef struct {
      logic [19:0]       rp;
      logic [19:0]       rt;
      logic [15:0]       rh;
      logic              fixed;
      ensc_pkg::rsp_type known;
   } stim_row_type;

   stim_row_type stim_table [$];

   env_sensor_compensation DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #100ms;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [31:0] sx(input logic [63:0] v, input int bits);
      logic [31:0] m;
      logic [31:0] x;
      m = (32'd1 << bits) - 32'd1;
      x = v[31:0] & m;
      if (x[bits-1]) x = x | ~m;
      return x;
   endfunction

   function automatic logic [31:0] shr_tz(input logic [31:0] x, input int k);
      logic [31:0] n;
      n = 32'd0 - x;
      return x[31] ? 32'd0 - (n >> k) : x >> k;
   endfunction

   function automatic ensc_pkg::rsp_type compensate(input logic [19:0] rp,
                                                    input logic [19:0] rt,
                                                    input logic [15:0] rh);
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
      logic [31:0] a, b, c, d, e, q, fine, p, hum;
      logic signed [31:0] ts, hs;
      ensc_pkg::rsp_type r;
      t1 = {16'd0, cal_words[0][15:0]};
      t2 = sx(cal_words[0] >> 16, 16);
      t3 = sx(cal_words[0] >> 32, 16);
      p1 = {16'd0, cal_words[1][15:0]};
      p2 = sx(cal_words[1] >> 16, 16);
      p3 = sx(cal_words[1] >> 32, 16);
      p4 = sx(cal_words[2], 16);
      p5 = sx(cal_words[2] >> 16, 16);
      p6 = sx(cal_words[2] >> 32, 16);
      p7 = sx(cal_words[3], 16);
      p8 = sx(cal_words[3] >> 16, 16);
      p9 = sx(cal_words[3] >> 32, 16);
      h1 = {24'd0, cal_words[4][7:0]};
      h2 = sx(cal_words[4] >> 8, 16);
      h3 = {24'd0, cal_words[4][31:24]};
      h4 = sx(cal_words[4] >> 32, 12);
      h5 = sx(cal_words[4] >> 44, 12);
      h6 = sx(cal_words[4] >> 56, 8);

      a = ({12'd0, rt} >> 3) - t1 * 32'd2;
      a = shr_tz(a * t2, 11);
      b = ({12'd0, rt} >> 4) - t1;
      b = shr_tz(shr_tz(b * b, 12) * t3, 14);
      fine = a + b;
      ts = shr_tz(fine * 32'd5 + 32'd128, 8);
      if (ts < -32'sd4000) ts = -32'sd4000;
      else if (ts > 32'sd8500) ts = 32'sd8500;

      a = shr_tz(fine, 1) - 32'd64000;
      q = shr_tz(a, 2);
      b = shr_tz(q * q, 11) * p6;
      b = b + (a * p5) * 32'd2;
      b = shr_tz(b, 2) + p4 * 32'd65536;
      c = shr_tz(p3 * shr_tz(q * q, 13), 3);
      d = shr_tz(p2 * a, 1);
      a = shr_tz(c + d, 18);
      a = shr_tz((32'd32768 + a) * p1, 15);
      if (a != 32'd0) begin
         e = 32'd1048576 - {12'd0, rp};
         p = (e - shr_tz(b, 12)) * 32'd3125;
         if (!p[31]) p = (p << 1) / a;
         else p = (p / a) * 32'd2;
         c = shr_tz(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
         d = shr_tz((p >> 2) * p8, 13);
         p = p + shr_tz(c + d + p7, 4);
         if (p < 32'd30000) p = 32'd30000;
         else if (p > 32'd110000) p = 32'd110000;
      end else begin
         p = 32'd30000;
      end

      a = fine - 32'd76800;
      b = {16'd0, rh} * 32'd16384;
      c = h4 * 32'd1048576;
      d = h5 * a;
      e = shr_tz(((b - c) - d) + 32'd16384, 15);
      b = shr_tz(a * h6, 10);
      c = shr_tz(a * h3, 11);
      d = shr_tz(b * (c + 32'd32768), 10) + 32'd2097152;
      b = shr_tz(d * h2 + 32'd8192, 14);
      c = e * b;
      d = shr_tz(shr_tz(c, 15) * shr_tz(c, 15), 7);
      e = c - shr_tz(d * h1, 4);
      hs = e;
      if (hs < 0) hs = 0;
      if (hs > 32'sd419430400) hs = 32'sd419430400;
      hum = hs >> 12;
      if (hum > 32'd102400) hum = 32'd102400;

      r.temperature_centi = ts[14:0];
      r.pressure_pa       = p[16:0];
      r.humidity_q10      = hum[16:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected word", 32'(rsp_word), 32'd0);
         end else begin
            ensc_pkg::rsp_type want;
            want = pending_rsp.pop_front();
            if (rsp_word.temperature_centi !== want.temperature_centi)
               report_mismatch("temperature", 32'(rsp_word.temperature_centi),
                               32'(want.temperature_centi));
            if (rsp_word.pressure_pa !== want.pressure_pa)
               report_mismatch("pressure", 32'(rsp_word.pressure_pa),
                               32'(want.pressure_pa));
            if (rsp_word.humidity_q10 !== want.humidity_q10)
               report_mismatch("humidity", 32'(rsp_word.humidity_q10),
                               32'(want.humidity_q10));
         end
      end
   end

   task automatic write_cal(input logic [2:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ensc_pkg::REG_TEMP, ensc_pkg::REG_PRESSA, ensc_pkg::REG_PRESSB,
         ensc_pkg::REG_PRESSC: begin
            cal_words[idx] = value & 64'hFFFF_FFFF_FFFF;
         end
         ensc_pkg::REG_HUM: begin
            cal_words[idx] = value;
         end
         default: begin
         end
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // one word; start stays high across back-to-back words
   task automatic send_word(input logic [19:0] rp, input logic [19:0] rt,
                            input logic [15:0] rh, input logic fixed,
                            input ensc_pkg::rsp_type known);
      while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_word <= '{raw_pressure: rp, raw_temperature: rt, raw_humidity: rh};
      do @(posedge clock); while (busy);
      pending_rsp.push_back(fixed ? known : compensate(rp, rt, rh));
   endtask

   task automatic load_typical;
      write_cal(ensc_pkg::REG_TEMP, 64'({16'd50, 16'd26435, 16'd27504}));
      write_cal(ensc_pkg::REG_PRESSA, 64'({16'd3024, 16'hD6D0, 16'd36477}));
      write_cal(ensc_pkg::REG_PRESSB, 64'({16'hFFF9, 16'hFF8B, 16'd2855}));
      write_cal(ensc_pkg::REG_PRESSC, 64'({16'd4285, 16'hD5F0, 16'd15500}));
      write_cal(ensc_pkg::REG_HUM, {8'd30, 12'd50, 12'd333, 8'd0, 16'd360, 8'd75});
   endtask

   task automatic load_random;
      write_cal(ensc_pkg::REG_TEMP, {$urandom(), $urandom()});
      write_cal(ensc_pkg::REG_PRESSA, {$urandom(), $urandom()});
      write_cal(ensc_pkg::REG_PRESSB, {$urandom(), $urandom()});
      write_cal(ensc_pkg::REG_PRESSC, {$urandom(), $urandom()});
      write_cal(ensc_pkg::REG_HUM, {$urandom(), $urandom()});
   endtask

   task automatic random_words(input int count, input int pct);
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3, 0) == 0)
            send_word(20'($urandom()), 20'($urandom()), 16'($urandom()), 1'b0, '0);
         else
            send_word(20'(32'd300000 + $urandom_range(250000, 0)),
                      20'(32'd400000 + $urandom_range(250000, 0)),
                      16'(32'd20000 + $urandom_range(20000, 0)), 1'b0, '0);
      end
      start <= 1'b0;
      idle_pct = 0;
   endtask

   initial begin
      stim_row_type row;
      error_count = 0;
      idle_pct = 0;
      for (int i = 0; i < 5; i++) cal_words[i] = '0;
      reset <= 1'b1;
      start <= 1'b0;
      req_word <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all calibration zero: zero divisor, temperature 0, humidity 0
      row = '{20'd0, 20'd0, 16'd0, 1'b1, '{15'sd0, 17'd30000, 17'd0}};
      stim_table.push_back(row);
      row = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1, '{15'sd0, 17'd30000, 17'd0}};
      stim_table.push_back(row);
      foreach (stim_table[i])
         send_word(stim_table[i].rp, stim_table[i].rt, stim_table[i].rh,
                   stim_table[i].fixed, stim_table[i].known);
      start <= 1'b0;
      drain();

      // out-of-range index is dropped
      write_cal(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
      load_typical();
      stim_table.delete();
      row = '{20'd415148, 20'd519888, 16'd30000, 1'b0, '0};
      stim_table.push_back(row);
      row = '{20'd0, 20'd0, 16'd0, 1'b0, '0};
      stim_table.push_back(row);
      row = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, '0};
      stim_table.push_back(row);
      row = '{20'hFFFFF, 20'd0, 16'd0, 1'b0, '0};
      stim_table.push_back(row);
      row = '{20'd0, 20'hFFFFF, 16'hFFFF, 1'b0, '0};
      stim_table.push_back(row);
      row = '{20'd500000, 20'd600000, 16'd65535, 1'b0, '0};
      stim_table.push_back(row);
      row = '{20'd200000, 20'd300000, 16'd1, 1'b0, '0};
      stim_table.push_back(row);
      row = '{20'h55555, 20'hAAAAA, 16'h5555, 1'b0, '0};
      stim_table.push_back(row);
      row = '{20'hAAAAA, 20'h55555, 16'hAAAA, 1'b0, '0};
      stim_table.push_back(row);
      foreach (stim_table[i])
         send_word(stim_table[i].rp, stim_table[i].rt, stim_table[i].rh,
                   stim_table[i].fixed, stim_table[i].known);
      start <= 1'b0;
      drain();

      // extreme calibration words
      write_cal(ensc_pkg::REG_TEMP, 64'hFFFF_FFFF_FFFF);
      write_cal(ensc_pkg::REG_PRESSA, 64'hFFFF_FFFF_FFFF);
      write_cal(ensc_pkg::REG_PRESSB, 64'h8000_8000_8000);
      write_cal(ensc_pkg::REG_PRESSC, 64'h7FFF_7FFF_7FFF);
      write_cal(ensc_pkg::REG_HUM, 64'hFFFF_FFFF_FFFF_FFFF);
      random_words(40, 0);
      drain();
      write_cal(ensc_pkg::REG_TEMP, 64'h8000_8000_FFFF);
      write_cal(ensc_pkg::REG_PRESSA, 64'h7FFF_7FFF_0000);
      write_cal(ensc_pkg::REG_HUM, 64'h8008_0000_8000_0000);
      random_words(40, 0);
      drain();

      load_typical();
      random_words(250, 0);
      drain();
      random_words(250, 51);
      // sender holds off until everything is back
      drain();
      load_random();
      random_words(150, 18);
      drain();
      load_typical();
      random_words(250, 51);
      drain();
      load_random();
      random_words(150, 0);
      drain();

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
